// ===== hdl/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants of the TFTP send engine.
// ----------------------------------------------------------------------------
package tse_pkg;

    typedef enum logic [2:0] {
        ACT_WAIT   = 3'd0,
        ACT_FETCH  = 3'd1,
        ACT_SEND   = 3'd2,
        ACT_RESEND = 3'd3,
        ACT_NAK    = 3'd4,
        ACT_DONE   = 3'd5,
        ACT_FAIL   = 3'd6
    } t_action;

    localparam logic [2:0] REQ_START    = 3'd0;
    localparam logic [2:0] REQ_HEADER   = 3'd1;
    localparam logic [2:0] REQ_TIMEOUT  = 3'd2;
    localparam logic [2:0] REQ_PAYLOAD  = 3'd3;
    localparam logic [2:0] REQ_READ_ERR = 3'd4;

    localparam logic [15:0] C_OP_ACK        = 16'd4;
    localparam logic [15:0] C_BLK_ALL_ONES  = 16'hffff;
    localparam logic [3:0]  C_FOREIGN_LIMIT = 4'd10;
    localparam logic [15:0] C_MAX_SEGMENT   = 16'd65464;

    localparam logic [15:0] C_BLOCK_SIZE_RST  = 16'd512;
    localparam logic [7:0]  C_RETRY_LIMIT_RST = 8'd5;

    localparam logic REG_BLOCK_SIZE  = 1'b0;
    localparam logic REG_RETRY_LIMIT = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] opcode;
        logic [15:0] ack_block;
        logic [15:0] payload_length;
    } t_item;

    typedef struct packed {
        t_action     action;
        logic [15:0] block_number;
        logic [15:0] send_length;
    } t_result;

    typedef struct packed {
        logic [15:0] block_size;
        logic [7:0]  retry_limit;
    } t_cfg;

endpackage

// ===== hdl/tse_if.sv =====
// ----------------------------------------------------------------------------
// tse_req_if / tse_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tse_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] opcode;
    logic [15:0] ack_block;
    logic [15:0] payload_length;

    modport source (output valid, req_type, opcode, ack_block, payload_length, input ready);
    modport sink   (input valid, req_type, opcode, ack_block, payload_length, output ready);
endinterface

interface tse_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] block_number;
    logic [15:0] send_length;

    modport source (output valid, action, block_number, send_length, input ready);
    modport sink   (input valid, action, block_number, send_length, output ready);
endinterface

// ===== hdl/tse_engine.sv =====
// ----------------------------------------------------------------------------
// tse_engine
// Transfer state and per-item decision logic; result registered on load.
// ----------------------------------------------------------------------------
module tse_engine
    import tse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_AWAIT0 = 3'd1,
        PH_FETCH  = 3'd2,
        PH_AWAIT  = 3'd3,
        PH_DONE   = 3'd4,
        PH_FAILED = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_cur_blk, n_cur_blk;
    logic [15:0] r_last_len, n_last_len;
    logic [7:0]  r_retry, n_retry;
    logic [3:0]  r_ignored, n_ignored;
    t_result     r_result, n_result;

    logic [15:0] next_blk;
    logic [15:0] eff_size;
    logic [3:0]  ign_inc;
    logic        is_ack;

    assign next_blk = r_cur_blk + 16'd1;
    assign eff_size = (i_cfg.block_size > C_MAX_SEGMENT) ? C_MAX_SEGMENT : i_cfg.block_size;
    assign ign_inc  = r_ignored + 4'd1;
    assign is_ack   = (i_item.opcode == C_OP_ACK);

    always_comb begin
        n_phase               = r_phase;
        n_cur_blk             = r_cur_blk;
        n_last_len            = r_last_len;
        n_retry               = r_retry;
        n_ignored             = r_ignored;
        n_result.action       = ACT_WAIT;
        n_result.block_number = r_cur_blk;
        n_result.send_length  = 16'd0;

        case (i_item.req_type)
            REQ_START: begin
                n_phase               = PH_AWAIT0;
                n_cur_blk             = 16'd0;
                n_last_len            = 16'd0;
                n_retry               = 8'd0;
                n_ignored             = 4'd0;
                n_result.block_number = 16'd0;
            end
            REQ_HEADER, REQ_TIMEOUT: begin
                if (r_phase == PH_AWAIT0) begin
                    if (i_item.req_type == REQ_TIMEOUT || !is_ack) begin
                        n_phase         = PH_FAILED;
                        n_result.action = ACT_FAIL;
                    end else if (i_item.ack_block == 16'd0 || i_item.ack_block == 16'd1) begin
                        n_phase               = PH_FETCH;
                        n_result.action       = ACT_FETCH;
                        n_result.block_number = next_blk;
                    end else if (i_item.ack_block == C_BLK_ALL_ONES) begin
                        n_phase         = PH_FAILED;
                        n_result.action = ACT_FAIL;
                    end else begin
                        n_ignored = ign_inc;
                        if (ign_inc >= C_FOREIGN_LIMIT) begin
                            n_phase         = PH_FAILED;
                            n_result.action = ACT_FAIL;
                        end
                    end
                end else if (r_phase == PH_AWAIT) begin
                    if (i_item.req_type == REQ_HEADER && !is_ack) begin
                        n_phase         = PH_FAILED;
                        n_result.action = ACT_FAIL;
                    end else if (i_item.req_type == REQ_HEADER
                                 && (i_item.ack_block == r_cur_blk
                                     || i_item.ack_block == next_blk)) begin
                        if (r_last_len < eff_size) begin
                            n_phase         = PH_DONE;
                            n_result.action = ACT_DONE;
                        end else begin
                            n_phase               = PH_FETCH;
                            n_result.action       = ACT_FETCH;
                            n_result.block_number = next_blk;
                        end
                    end else if (i_item.req_type == REQ_TIMEOUT
                                 || i_item.ack_block == C_BLK_ALL_ONES
                                 || ign_inc >= C_FOREIGN_LIMIT) begin
                        if (i_item.req_type == REQ_HEADER
                            && i_item.ack_block != C_BLK_ALL_ONES) begin
                            n_ignored = ign_inc;
                        end
                        if (r_retry < i_cfg.retry_limit) begin
                            n_retry              = r_retry + 8'd1;
                            n_ignored            = 4'd0;
                            n_result.action      = ACT_RESEND;
                            n_result.send_length = r_last_len;
                        end else begin
                            n_phase         = PH_FAILED;
                            n_result.action = ACT_FAIL;
                        end
                    end else begin
                        n_ignored = ign_inc;
                    end
                end
            end
            REQ_PAYLOAD: begin
                if (r_phase == PH_FETCH) begin
                    n_cur_blk             = next_blk;
                    n_last_len            = (i_item.payload_length > eff_size)
                                            ? eff_size : i_item.payload_length;
                    n_retry               = 8'd0;
                    n_ignored             = 4'd0;
                    n_phase               = PH_AWAIT;
                    n_result.action       = ACT_SEND;
                    n_result.block_number = next_blk;
                    n_result.send_length  = n_last_len;
                end
            end
            REQ_READ_ERR: begin
                if (r_phase == PH_FETCH) begin
                    n_phase         = PH_FAILED;
                    n_result.action = ACT_NAK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cur_blk  <= 16'd0;
            r_last_len <= 16'd0;
            r_retry    <= 8'd0;
            r_ignored  <= 4'd0;
        end else if (i_load) begin
            r_phase    <= n_phase;
            r_cur_blk  <= n_cur_blk;
            r_last_len <= n_last_len;
            r_retry    <= n_retry;
            r_ignored  <= n_ignored;
            r_result   <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// ===== hdl/tftp_send_engine.sv =====
// ----------------------------------------------------------------------------
// tftp_send_engine
// TFTP write-side sequencer: one decision item per request item.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries events (start, header received, timeout, payload ready,
//   payload read error); o_rsp returns exactly one result item per event:
//   the action to take, the block number and the payload length to send.
//   block_size and retry_limit are written over the APB port at byte
//   addresses 0 and 4; write them only while the engine is idle.
// Timing:
//   An accepted item waits in the input register; once the output is free
//   its result is registered and shown on o_rsp, and the transfer state
//   updates with it. One item per cycle is sustained unless o_rsp is held off.
// Reset:
//   Synchronous active-low reset returns the engine to idle, clears the
//   transfer state and loads block_size 512 and retry_limit 5.
// Stall:
//   While o_rsp is held off the result register keeps its item; one more
//   item is taken into the input register, then i_req.ready drops.
// ----------------------------------------------------------------------------
module tftp_send_engine
    import tse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tse_req_if.sink     i_req,
    tse_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        r_in_vld;
    t_item       r_in;
    logic        r_out_vld;
    logic [15:0] r_block_size;
    logic [7:0]  r_retry_limit;

    logic        out_free;
    logic        fire;
    logic        in_take;
    logic        cfg_wr;
    t_cfg        cfg;
    t_result     result;

    assign out_free    = !r_out_vld || o_rsp.ready;
    assign fire        = r_in_vld && out_free;
    assign i_req.ready = !r_in_vld || out_free;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.req_type       <= i_req.req_type;
            r_in.opcode         <= i_req.opcode;
            r_in.ack_block      <= i_req.ack_block;
            r_in.payload_length <= i_req.payload_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= C_BLOCK_SIZE_RST;
            r_retry_limit <= C_RETRY_LIMIT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BLOCK_SIZE) begin
                r_block_size <= pwdata[15:0];
            end else begin
                r_retry_limit <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_RETRY_LIMIT) ? {24'd0, r_retry_limit}
                                                  : {16'd0, r_block_size};

    assign cfg.block_size  = r_block_size;
    assign cfg.retry_limit = r_retry_limit;

    tse_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.action       = result.action;
    assign o_rsp.block_number = result.block_number;
    assign o_rsp.send_length  = result.send_length;

endmodule

// ===== hdl/tse_checker.sv =====
// ----------------------------------------------------------------------------
// tse_checker
// Port-level checks of the TFTP send engine, bound to the top level.
// ----------------------------------------------------------------------------
module tse_checker
    import tse_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [2:0]  i_rsp_action,
    input logic [15:0] i_rsp_send_length
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("stalled result dropped");

    a_len_only_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_action != ACT_SEND && i_rsp_action != ACT_RESEND
        |-> i_rsp_send_length == 16'd0)
        else $error("length on a non-send action");

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_send_length <= C_MAX_SEGMENT)
        else $error("send length above segment limit");

endmodule

bind tftp_send_engine tse_checker u_tse_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_action      (o_rsp.action),
    .i_rsp_send_length (o_rsp.send_length)
);
